[rtl/core/elevation_color_ramp_top_assert.svh]
// Assertion macros for the elevation color ramp.
// Used by the interpolation pipeline module; needs a clock and a synchronous reset in scope.
`ifndef ELEVATION_COLOR_RAMP_TOP_ASSERT_SVH
`define ELEVATION_COLOR_RAMP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ECR_ASSERT_IMPL(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ECR_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ecr_pkg.sv]
// Shared constants, types and breakpoint field helpers for the color ramp.
// No dependencies; imported by every module of the block.
`default_nettype none

package ecr_pkg;

  localparam int MAX_POINTS     = 6;
  localparam int FRACTION_BITS  = 4;
  localparam int NUM_POINT_REGS = 6;

  localparam int ELEV_W    = 16;
  localparam int BP_W      = 20;
  localparam int COLOR_W   = 8;
  localparam int NUM_CH    = 3;
  localparam int PT_W      = BP_W + NUM_CH * COLOR_W;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;

  // Scaled sample width and the signed width that holds any difference
  localparam int X_W   = ELEV_W + FRACTION_BITS;
  localparam int CMP_W = ((X_W > BP_W) ? X_W : BP_W) + 1;

  // Divider: dividend is offset times color step, quotient is one color
  localparam int DX_W        = BP_W;
  localparam int N_W         = DX_W + COLOR_W;
  localparam int BITS_PER_ST = 2;
  localparam int DIV_STAGES  = COLOR_W / BITS_PER_ST;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINTS_IN_USE = 3'd0,
    REG_POINT_ZERO    = 3'd1,
    REG_POINT_ONE     = 3'd2,
    REG_POINT_TWO     = 3'd3,
    REG_POINT_THREE   = 3'd4,
    REG_POINT_FOUR    = 3'd5,
    REG_POINT_FIVE    = 3'd6
  } cfg_reg_t;

  // Segment chosen for one sample, handed to the interpolator
  typedef struct packed {
    logic [DX_W-1:0]                  dx;
    logic [DX_W-1:0]                  w;
    logic [NUM_CH-1:0][COLOR_W-1:0]   c0;
    logic [NUM_CH-1:0][COLOR_W-1:0]   dmag;
    logic [NUM_CH-1:0]                dneg;
    logic                             flat;
    logic                             clamp;
  } ecr_seg_t;

  // Sign-extended breakpoint elevation
  function automatic logic signed [CMP_W-1:0] bp_elev(input logic [PT_W-1:0] p);
    logic signed [BP_W-1:0] e;
    e = signed'(p[BP_W-1:0]);
    return CMP_W'(e);
  endfunction

  // One color channel: 0 blue, 1 green, 2 red
  function automatic logic [COLOR_W-1:0] bp_chan(input logic [PT_W-1:0] p, input int ch);
    return p[BP_W + COLOR_W * ch +: COLOR_W];
  endfunction

endpackage

`default_nettype wire

[rtl/core/elevation_color_ramp_top.sv]
// Top level of the elevation color ramp: configuration registers and segment search.
// Depends on ecr_pkg and ecr_interp.
`default_nettype none

// Maps one signed elevation sample per clock to a BGR pixel through up to six
// ascending breakpoints, while the output side does not stall. The pipeline is
// eight register stages deep: compare against all breakpoints, select the segment,
// multiply, four divider stages of two quotient bits each, and the output register.
// A sample can be accepted in every cycle unless the pipeline is stalled; empty
// stages are filled while a finished pixel waits. Breakpoint and count registers
// are written through the configuration channel, which is always ready and must
// only be used while no sample is in flight.
module elevation_color_ramp_top import ecr_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic signed [ELEV_W-1:0]    elevation,
  output logic                        pixel_valid,
  input  logic                        pixel_stall,
  output logic [COLOR_W-1:0]          blue,
  output logic [COLOR_W-1:0]          green,
  output logic [COLOR_W-1:0]          red,
  output logic                        clamped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [PT_W-1:0]             cfg_data
);

  logic [COUNT_W-1:0]    points_in_use;
  logic [PT_W-1:0]       points [MAX_POINTS];
  logic [COUNT_W:0]      n_eff;
  logic [MAX_POINTS-1:0] last_sel;

  logic signed [CMP_W-1:0] x_in;
  logic [MAX_POINTS-1:0]   lt_in;
  logic                    gt_in;
  logic [PT_W-1:0]         p_last;

  logic                    v1;
  logic signed [CMP_W-1:0] x1;
  logic [MAX_POINTS-1:0]   lt1;
  logic                    gt1;
  logic                    en1;

  ecr_seg_t                seg_next;
  ecr_seg_t                s2;
  logic                    v2;
  logic                    en2;
  logic                    interp_stall;

  // Configuration writes; never back-pressured
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= COUNT_W'(NUM_POINT_REGS);
      for (int k = 0; k < MAX_POINTS; k++) begin
        points[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_POINTS_IN_USE) begin
        points_in_use <= cfg_data[COUNT_W-1:0];
      end
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (k < NUM_POINT_REGS &&
            cfg_index == CFG_IDX_W'(int'(REG_POINT_ZERO) + k)) begin
          points[k] <= cfg_data;
        end
      end
    end
  end

  // Clamp the point count and mark the last breakpoint in use
  always_comb begin
    if ({1'b0, points_in_use} < (COUNT_W+1)'(2)) begin
      n_eff = (COUNT_W+1)'(2);
    end else if ({1'b0, points_in_use} > (COUNT_W+1)'(MAX_POINTS)) begin
      n_eff = (COUNT_W+1)'(MAX_POINTS);
    end else begin
      n_eff = {1'b0, points_in_use};
    end
    for (int k = 0; k < MAX_POINTS; k++) begin
      last_sel[k] = (n_eff == (COUNT_W+1)'(k + 1));
    end
  end

  // Stage 1: scale the sample and compare it with every breakpoint
  always_comb begin
    x_in   = CMP_W'(elevation) <<< FRACTION_BITS;
    p_last = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      lt_in[k] = x_in < bp_elev(points[k]);
      if (last_sel[k]) begin
        p_last = p_last | points[k];
      end
    end
    gt_in = x_in > bp_elev(p_last);
  end

  // Stage 2: pick the segment and form offset, width and color steps
  always_comb begin
    logic [MAX_POINTS-1:0]   seg_sel;
    logic                    found;
    logic                    below;
    logic                    ge_last;
    logic [PT_W-1:0]         lo;
    logic [PT_W-1:0]         hi;
    logic [PT_W-1:0]         p_end;
    logic signed [CMP_W-1:0] w_s;
    logic signed [CMP_W-1:0] dx_s;
    logic signed [COLOR_W:0] dc;
    seg_sel = '0;
    found   = 1'b0;
    lo      = '0;
    hi      = '0;
    p_end   = '0;
    for (int k = 0; k + 1 < MAX_POINTS; k++) begin
      seg_sel[k] = !found && lt1[k+1];
      found      = found || lt1[k+1];
      if (seg_sel[k]) begin
        lo = lo | points[k];
        hi = hi | points[k+1];
      end
    end
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (last_sel[k]) begin
        p_end = p_end | points[k];
      end
    end
    below   = lt1[0];
    ge_last = !(|(lt1 & last_sel));
    if (below) begin
      lo = points[0];
      hi = points[0];
    end else if (ge_last) begin
      lo = p_end;
      hi = p_end;
    end
    w_s  = bp_elev(hi) - bp_elev(lo);
    dx_s = x1 - bp_elev(lo);

    seg_next.clamp = below || gt1;
    seg_next.flat  = below || ge_last || w_s[CMP_W-1] || (w_s == '0);
    seg_next.dx    = seg_next.flat ? '0 : dx_s[DX_W-1:0];
    seg_next.w     = seg_next.flat ? DX_W'(1) : w_s[DX_W-1:0];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      dc = signed'({1'b0, bp_chan(hi, ch)}) - signed'({1'b0, bp_chan(lo, ch)});
      seg_next.c0[ch]   = bp_chan(lo, ch);
      seg_next.dneg[ch] = dc[COLOR_W];
      if (seg_next.flat) begin
        seg_next.dmag[ch] = '0;
      end else if (dc[COLOR_W]) begin
        seg_next.dmag[ch] = COLOR_W'(-dc);
      end else begin
        seg_next.dmag[ch] = dc[COLOR_W-1:0];
      end
    end
  end

  // Stage enables: advance when empty or when the next stage takes the item
  assign en2          = !v2 || !interp_stall;
  assign en1          = !v1 || en2;
  assign sample_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= sample_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1  <= x_in;
      lt1 <= lt_in;
      gt1 <= gt_in;
    end
    if (en2) begin
      s2 <= seg_next;
    end
  end

  // Multiply, divide and blend
  ecr_interp u_interp (
    .clk         (clk),
    .rst         (rst),
    .seg_valid   (v2),
    .seg_stall   (interp_stall),
    .seg         (s2),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .clamped     (clamped)
  );

endmodule

`default_nettype wire

[rtl/core/ecr_interp.sv]
// Interpolation pipeline: offset times color step, then a staged restoring divider.
// Depends on ecr_pkg and the assertion macro header.
`default_nettype none
`include "elevation_color_ramp_top_assert.svh"

module ecr_interp import ecr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                seg_valid,
  output logic                seg_stall,
  input  ecr_seg_t            seg,
  output logic                pixel_valid,
  input  logic                pixel_stall,
  output logic [COLOR_W-1:0]  blue,
  output logic [COLOR_W-1:0]  green,
  output logic [COLOR_W-1:0]  red,
  output logic                clamped
);

  localparam int NS = DIV_STAGES + 2;

  typedef struct packed {
    logic [NUM_CH-1:0][N_W-1:0]      rem;
    logic [NUM_CH-1:0][COLOR_W-1:0]  quo;
    logic [DX_W-1:0]                 w;
    logic [NUM_CH-1:0][COLOR_W-1:0]  c0;
    logic [NUM_CH-1:0]               dneg;
    logic                            flat;
    logic                            clamp;
  } div_t;

  logic [NS-1:0]  vld;
  logic [NS-1:0]  en;
  div_t           st [DIV_STAGES+1];
  div_t           mul_next;
  div_t           div_next [DIV_STAGES];
  logic [NUM_CH-1:0][COLOR_W-1:0] color_next;
  logic [NUM_CH-1:0][COLOR_W-1:0] color;
  logic           flat_out;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS-1] = !vld[NS-1] || !pixel_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign seg_stall = !en[0];

  // Form dividend: offset times color step magnitude
  always_comb begin
    mul_next = '0;
    mul_next.w     = seg.w;
    mul_next.c0    = seg.c0;
    mul_next.dneg  = seg.dneg;
    mul_next.flat  = seg.flat;
    mul_next.clamp = seg.clamp;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      mul_next.rem[ch] = N_W'(seg.dx) * N_W'(seg.dmag[ch]);
    end
  end

  // Resolve two quotient bits per stage, most significant first
  always_comb begin
    div_t              d;
    logic [N_W-1:0]    trial;
    int                b;
    d     = '0;
    trial = '0;
    b     = 0;
    for (int j = 0; j < DIV_STAGES; j++) begin
      d = st[j];
      for (int s = 0; s < BITS_PER_ST; s++) begin
        b = COLOR_W - 1 - (j * BITS_PER_ST + s);
        trial = N_W'(d.w) << b;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (d.rem[ch] >= trial) begin
            d.rem[ch]    = d.rem[ch] - trial;
            d.quo[ch][b] = 1'b1;
          end
        end
      end
      div_next[j] = d;
    end
  end

  // Apply the sign of the color step and add the base color
  always_comb begin
    div_t last;
    last = st[DIV_STAGES];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (last.flat) begin
        color_next[ch] = last.c0[ch];
      end else if (last.dneg[ch]) begin
        color_next[ch] = last.c0[ch] - last.quo[ch];
      end else begin
        color_next[ch] = last.c0[ch] + last.quo[ch];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= seg_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0] <= mul_next;
    end
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[j+1]) begin
        st[j+1] <= div_next[j];
      end
    end
    if (en[NS-1]) begin
      color    <= color_next;
      clamped  <= st[DIV_STAGES].clamp;
      flat_out <= st[DIV_STAGES].flat;
    end
  end

  assign pixel_valid = vld[NS-1];
  assign blue        = color[0];
  assign green       = color[1];
  assign red         = color[2];

  // Interior dividend must leave a quotient that fits one color
  `ECR_ASSERT_IMPL(a_dividend_bound, clk, rst, vld[0] && !st[0].flat, (st[0].rem[0] < (N_W'(st[0].w) << COLOR_W)) && (st[0].rem[1] < (N_W'(st[0].w) << COLOR_W)) && (st[0].rem[2] < (N_W'(st[0].w) << COLOR_W)), "dividend too large for color quotient")
  // Final remainder is below the divisor on every channel
  `ECR_ASSERT_IMPL(a_final_remainder, clk, rst, vld[NS-2] && !st[DIV_STAGES].flat, (st[DIV_STAGES].rem[0] < N_W'(st[DIV_STAGES].w)) && (st[DIV_STAGES].rem[1] < N_W'(st[DIV_STAGES].w)) && (st[DIV_STAGES].rem[2] < N_W'(st[DIV_STAGES].w)), "divider remainder not reduced")
  // A clamped pixel never comes from interpolation
  `ECR_ASSERT_IMPL(a_clamp_is_flat, clk, rst, pixel_valid && clamped, flat_out, "clamped pixel was interpolated")
  // A blocked first stage keeps its item
  `ECR_ASSERT_NEXT(a_mul_hold, clk, rst, vld[0] && !en[0], vld[0] && $stable(st[0]), "blocked multiply stage lost its item")

endmodule

`default_nettype wire

[tb/sv/elevation_color_ramp_top_tb.sv]
// Self-checking bench for elevation_color_ramp_top: loads ramp tables over the register
// channel, streams elevation samples and checks every pixel beat against its own prediction.
// Depends on ecr_pkg and the color ramp RTL.
module elevation_color_ramp_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecr_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int PARK_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 12;
  localparam int MAX_GAP         = 12;
  localparam int RANDOM_RAMPS    = 10;
  localparam int SAMPLES_PER_RAMP = 80;
  localparam int PARK_RAMP       = 4;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef enum int {RAMP_NARROW, RAMP_WIDE, RAMP_SCRAMBLED} ramp_kind_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               clamped;
  } pixel_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic signed [ELEV_W-1:0] elevation = '0;
  logic                     pixel_valid;
  logic                     pixel_stall = 1'b0;
  logic [COLOR_W-1:0]       blue, green, red;
  logic                     clamped;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [PT_W-1:0]          cfg_data = '0;

  // Mirror of the ramp registers
  logic [COUNT_W-1:0] ramp_count = 3'd6;
  logic [PT_W-1:0]    ramp_point [MAX_POINTS] = '{default: '0};

  logic signed [ELEV_W-1:0] sample_backlog [$];
  pixel_t                   pending_pixels [$];
  int samples_queued = 0, samples_taken = 0, pixels_checked = 0;
  int mismatches = 0, reg_writes = 0, ramps_run = 0;
  int gap_left = 0, hold_left = 0;
  logic sample_took = 1'b0, pixel_took = 1'b0;
  logic src_gappy = 1'b0, sink_gappy = 1'b0, park_req = 1'b0;

  // Sample probes around the named ramp: extremes, breakpoints and their neighbors
  int ramp_probes [17] = '{-32768, 32767, -2, -1, 0, 1, 19, 20, 50, 75, 76, 99, 100, 150,
                           199, 200, 201};
  int count_sweep [8] = '{6, 0, 7, 2, 1, 3, 4, 5};

  elevation_color_ramp_top uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .elevation    (elevation),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .clamped      (clamped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint point_elev(input logic [PT_W-1:0] p);
    return longint'($signed(p[BP_W-1:0]));
  endfunction

  function automatic logic [PT_W-1:0] pack_point(input longint e, input int b, input int g,
                                                 input int r);
    return {COLOR_W'(r), COLOR_W'(g), COLOR_W'(b), BP_W'(e)};
  endfunction

  // Color one sample through the mirrored ramp
  function automatic pixel_t ramp_color(input logic signed [ELEV_W-1:0] elev);
    longint x, w, dx, c0, dc;
    int n, seg;
    logic [PT_W-1:0] lo, hi;
    logic [COLOR_W-1:0] chan [NUM_CH];
    pixel_t px;
    x = longint'(elev) * (longint'(1) << FRACTION_BITS);
    n = int'(ramp_count);
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    seg = 0;
    w = 0;
    px.clamped = 1'b0;
    if (x < point_elev(ramp_point[0])) begin
      lo = ramp_point[0];
      hi = lo;
      px.clamped = 1'b1;
    end else if (x >= point_elev(ramp_point[n-1])) begin
      lo = ramp_point[n-1];
      hi = lo;
      px.clamped = (x > point_elev(lo));
    end else begin
      // take the lowest segment whose upper breakpoint lies above the sample
      for (int k = n - 2; k >= 0; k--) begin
        if (x < point_elev(ramp_point[k+1])) seg = k;
      end
      lo = ramp_point[seg];
      hi = ramp_point[seg+1];
      w = point_elev(hi) - point_elev(lo);
    end
    dx = x - point_elev(lo);
    // interpolate each channel, quotient truncated toward zero; flat when width is not positive
    for (int ch = 0; ch < NUM_CH; ch++) begin
      c0 = longint'(lo[BP_W + COLOR_W*ch +: COLOR_W]);
      dc = longint'(hi[BP_W + COLOR_W*ch +: COLOR_W]) - c0;
      if (w > 0) c0 = c0 + (dx * dc) / w;
      chan[ch] = COLOR_W'(c0);
    end
    px.blue  = chan[0];
    px.green = chan[1];
    px.red   = chan[2];
    return px;
  endfunction

  // Sample beats, pixel beats and register beats
  always @(posedge clk) begin : monitor
    pixel_t got, want;
    if (rst) begin
      sample_took <= 1'b0;
      pixel_took  <= 1'b0;
    end else begin
      sample_took <= sample_valid && !sample_stall;
      pixel_took  <= pixel_valid && !pixel_stall;
      // mirror register writes; the unused index is dropped
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        if (cfg_index == REG_POINTS_IN_USE) begin
          ramp_count <= cfg_data[COUNT_W-1:0];
        end else if (cfg_index <= REG_POINT_FIVE) begin
          ramp_point[int'(cfg_index) - int'(REG_POINT_ZERO)] <= cfg_data;
        end
      end
      if (sample_valid && !sample_stall) begin
        pending_pixels.insert(pending_pixels.size(), ramp_color(elevation));
        samples_taken++;
      end
      if (pixel_valid && !pixel_stall) begin
        pixels_checked++;
        got = {blue, green, red, clamped};
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: pixel beat with no sample pending: b=%0d g=%0d r=%0d clamped=%0b",
                   $time, blue, green, red, clamped);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: pixel mismatch: expected b=%0d g=%0d r=%0d clamped=%0b,",
                     $time, want.blue, want.green, want.red, want.clamped);
            $display("    actual b=%0d g=%0d r=%0d clamped=%0b",
                     got.blue, got.green, got.red, got.clamped);
          end
        end
      end
    end
  end

  // Offer samples from the backlog; hold a stalled beat, then idle for the drawn gap
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample_valid && !sample_took) begin
      sample_valid <= 1'b1;
    end else if (gap_left > 0) begin
      sample_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (sample_backlog.size() > 0) begin
      elevation    <= sample_backlog.pop_front();
      sample_valid <= 1'b1;
      gap_left = src_gappy ? $urandom_range(0, MAX_GAP) : 0;
    end else begin
      sample_valid <= 1'b0;
    end
  end

  // Stall the pixel side: a drawn hold after each beat when the sink is gappy, or one long park on request
  always @(negedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
    end else if (park_req) begin
      pixel_stall <= 1'b1;
      hold_left = PARK_CYCLES;
      park_req = 1'b0;
    end else if (hold_left > 0) begin
      pixel_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (pixel_took && sink_gappy) begin
      hold_left = $urandom_range(0, MAX_GAP);
      pixel_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left = hold_left - 1;
    end else begin
      pixel_stall <= 1'b0;
    end
  end

  // End the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (pixel_valid && !pixel_stall) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_sample(input int m);
    sample_backlog.insert(sample_backlog.size(), ELEV_W'(m));
    samples_queued++;
  endtask

  // Wait until every sample is taken and every pixel checked, then let the pipe settle
  task automatic wait_idle();
    while (samples_taken != samples_queued || pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    ramps_run++;
  endtask

  // Load one random ramp and stream samples through it
  task automatic random_ramp(input int idx);
    logic [PT_W-1:0] pts [MAX_POINTS];
    logic [PT_W-1:0] data;
    ramp_kind_t kind;
    longint e;
    int cnt, n, pick, elev;
    cnt  = (idx < 8) ? count_sweep[idx] : $urandom_range(0, 7);
    kind = ramp_kind_t'(idx % 3);
    e = (kind == RAMP_WIDE) ? -524288 + longint'($urandom_range(0, 2000))
                            : -longint'($urandom_range(0, 8000));
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (kind == RAMP_SCRAMBLED) begin
        pts[i] = PT_W'({$urandom, $urandom});
      end else begin
        pts[i] = pack_point(e, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
        e = e + ((kind == RAMP_WIDE) ? longint'($urandom_range(1, 200000))
                                     : longint'($urandom_range(1, 2500)));
      end
    end
    data = PT_W'({$urandom, $urandom});
    data[COUNT_W-1:0] = COUNT_W'(cnt);
    write_reg(REG_POINTS_IN_USE, data);
    for (int i = 0; i < MAX_POINTS; i++) write_reg(CFG_IDX_W'(int'(REG_POINT_ZERO) + i), pts[i]);
    n = (cnt < 2) ? 2 : (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
    @(posedge clk);
    src_gappy  <= (idx % 4 == 1) || (idx % 4 == 3);
    sink_gappy <= (idx % 4 == 2) || (idx % 4 == 3);
    if (idx == PARK_RAMP) park_req <= 1'b1;
    // mostly samples near a breakpoint in use, the rest anywhere
    for (int k = 0; k < SAMPLES_PER_RAMP; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, n - 1);
        elev = int'(point_elev(pts[pick]) >>> FRACTION_BITS) + int'($urandom_range(0, 80)) - 40;
        if (elev > 32767) elev = 32767;
        if (elev < -32768) elev = -32768;
      end else begin
        elev = $urandom_range(0, 65535);
      end
      queue_sample(elev);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset table: all breakpoints at zero, six in use
    @(posedge clk);
    queue_sample(-1);
    queue_sample(0);
    queue_sample(1);
    wait_idle();

    // Named ramp from below sea level to the hilltops
    write_reg(REG_POINTS_IN_USE, PT_W'(6));
    write_reg(REG_POINT_ZERO,  pack_point(-16,  255, 0,   0));
    write_reg(REG_POINT_ONE,   pack_point(4,    200, 180, 20));
    write_reg(REG_POINT_TWO,   pack_point(320,  0,   160, 40));
    write_reg(REG_POINT_THREE, pack_point(1200, 30,  120, 200));
    write_reg(REG_POINT_FOUR,  pack_point(1600, 60,  60,  140));
    write_reg(REG_POINT_FIVE,  pack_point(3200, 255, 255, 255));
    @(posedge clk);
    foreach (ramp_probes[i]) queue_sample(ramp_probes[i]);
    wait_idle();

    // Descending ends: below first and above last at once
    write_reg(REG_POINT_ZERO, pack_point(3200, 10, 20, 30));
    write_reg(REG_POINT_FIVE, pack_point(-16, 40, 50, 60));
    @(posedge clk);
    queue_sample(0);
    queue_sample(300);
    wait_idle();

    // Unused index dropped, count below two, one segment spanning the whole range
    write_reg(REG_NONE, '1);
    write_reg(REG_POINTS_IN_USE, PT_W'(1));
    write_reg(REG_POINT_ZERO, pack_point(-524288, 0, 255, 17));
    write_reg(REG_POINT_ONE, pack_point(524287, 255, 0, 200));
    @(posedge clk);
    queue_sample(-32768);
    queue_sample(32767);
    wait_idle();

    // Count above the table size
    write_reg(REG_POINTS_IN_USE, PT_W'(7));
    @(posedge clk);
    queue_sample(100);
    queue_sample(-100);
    wait_idle();

    for (int r = 0; r < RANDOM_RAMPS; r++) random_ramp(r);

    $display("Mapped %0d samples through %0d ramp settings using %0d register writes,",
             samples_taken, ramps_run, reg_writes);
    $display("with gaps, stalls and one long park; %0d pixels compared, %0d mismatched.",
             pixels_checked, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ecr_pkg.sv
rtl/core/ecr_interp.sv
rtl/core/elevation_color_ramp_top.sv
tb/sv/elevation_color_ramp_top_tb.sv
